FILE: rtl/assert_macros.svh
// Assertion macros shared by the timer RTL.
// Each check samples on the rising edge of clk and is held off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication, checked at the same edge.
`define ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Implication, checked at the edge after.
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: rtl/dtr_pkg.sv
// Shared types, constants and helpers for the divider/counter timer.
// No dependencies.
`timescale 1ns / 1ps

package dtr_pkg;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned ACCUM_W  = 17;
  localparam int unsigned PADDR_W  = 5;
  localparam int unsigned NUM_SEL  = 4;

  localparam logic [ACCUM_W-1:0] ACCUM_MAX = {ACCUM_W{1'b1}};

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [15:0] ADDR_DIVIDER = 16'hFF04;
  localparam logic [15:0] ADDR_COUNTER = 16'hFF05;
  localparam logic [15:0] ADDR_MODULO  = 16'hFF06;
  localparam logic [15:0] ADDR_CONTROL = 16'hFF07;
  localparam logic [7:0]  UNMAPPED_READ = 8'hFF;

  localparam logic [2:0] REG_DIV_PERIOD = 3'd0;
  localparam logic [2:0] REG_CNT_SEL0   = 3'd1;
  localparam logic [2:0] REG_CNT_SEL1   = 3'd2;
  localparam logic [2:0] REG_CNT_SEL2   = 3'd3;
  localparam logic [2:0] REG_CNT_SEL3   = 3'd4;

  localparam logic [PERIOD_W-1:0] RST_DIV_PERIOD = 16'd256;
  localparam logic [PERIOD_W-1:0] RST_CNT_SEL0   = 16'd1024;
  localparam logic [PERIOD_W-1:0] RST_CNT_SEL1   = 16'd16;
  localparam logic [PERIOD_W-1:0] RST_CNT_SEL2   = 16'd64;
  localparam logic [PERIOD_W-1:0] RST_CNT_SEL3   = 16'd256;

  localparam int unsigned CTRL_ENABLE_BIT = 2;

  typedef struct packed {
    logic [PERIOD_W-1:0]              divider_period;
    logic [NUM_SEL-1:0][PERIOD_W-1:0] counter_period;
  } cfg_t;

  // a period of zero behaves as one
  function automatic logic [PERIOD_W-1:0] eff_period(input logic [PERIOD_W-1:0] p);
    eff_period = (p == '0) ? PERIOD_W'(1) : p;
  endfunction

endpackage

FILE: rtl/dtr_sub.sv
// Shared compare/subtract unit: accumulator minus period, with a no-borrow flag.
// Depends on dtr_pkg.
`timescale 1ns / 1ps

module dtr_sub (
  input  logic [dtr_pkg::ACCUM_W-1:0]  a,
  input  logic [dtr_pkg::PERIOD_W-1:0] b,
  output logic [dtr_pkg::ACCUM_W-1:0]  diff,
  output logic                         ge
);

  logic [dtr_pkg::ACCUM_W:0] full;

  assign full = {1'b0, a} - {2'b00, b};
  assign ge   = ~full[dtr_pkg::ACCUM_W];
  assign diff = full[dtr_pkg::ACCUM_W-1:0];

endmodule

FILE: rtl/dtr_apb_regs.sv
// APB configuration registers: divider period and the four counter periods.
// Depends on dtr_pkg.
`timescale 1ns / 1ps

module dtr_apb_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dtr_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output dtr_pkg::cfg_t                cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[dtr_pkg::PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.divider_period    <= dtr_pkg::RST_DIV_PERIOD;
      cfg.counter_period[0] <= dtr_pkg::RST_CNT_SEL0;
      cfg.counter_period[1] <= dtr_pkg::RST_CNT_SEL1;
      cfg.counter_period[2] <= dtr_pkg::RST_CNT_SEL2;
      cfg.counter_period[3] <= dtr_pkg::RST_CNT_SEL3;
    end else if (wr_en) begin
      case (idx)
        dtr_pkg::REG_DIV_PERIOD: cfg.divider_period    <= pwdata[15:0];
        dtr_pkg::REG_CNT_SEL0:   cfg.counter_period[0] <= pwdata[15:0];
        dtr_pkg::REG_CNT_SEL1:   cfg.counter_period[1] <= pwdata[15:0];
        dtr_pkg::REG_CNT_SEL2:   cfg.counter_period[2] <= pwdata[15:0];
        dtr_pkg::REG_CNT_SEL3:   cfg.counter_period[3] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dtr_pkg::REG_DIV_PERIOD: prdata = {16'h0000, cfg.divider_period};
      dtr_pkg::REG_CNT_SEL0:   prdata = {16'h0000, cfg.counter_period[0]};
      dtr_pkg::REG_CNT_SEL1:   prdata = {16'h0000, cfg.counter_period[1]};
      dtr_pkg::REG_CNT_SEL2:   prdata = {16'h0000, cfg.counter_period[2]};
      dtr_pkg::REG_CNT_SEL3:   prdata = {16'h0000, cfg.counter_period[3]};
      default:                 prdata = 32'h0000_0000;
    endcase
  end

endmodule

FILE: rtl/dtr_seq.sv
// Timer sequencer: register file, cycle accumulators and the tick loop.
// Depends on dtr_pkg and dtr_sub.
`timescale 1ns / 1ps

module dtr_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    kind,
  input  logic [15:0]                   address,
  input  logic [7:0]                    write_data,
  input  logic [7:0]                    delta_cycles,
  input  dtr_pkg::cfg_t                 cfg,
  output logic                          done,
  output logic [7:0]                    read_data,
  output logic                          timer_irq
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_CNT
  } state_t;

  state_t state;

  logic [7:0] divider_reg;
  logic [7:0] counter_reg;
  logic [7:0] modulo_reg;
  logic [7:0] control_reg;
  logic [dtr_pkg::ACCUM_W-1:0] divider_accum;
  logic [dtr_pkg::ACCUM_W-1:0] counter_accum;
  logic irq_flag;

  logic [dtr_pkg::ACCUM_W-1:0]  sub_a;
  logic [dtr_pkg::PERIOD_W-1:0] sub_b;
  logic [dtr_pkg::ACCUM_W-1:0]  sub_diff;
  logic                         sub_ge;
  logic [dtr_pkg::ACCUM_W-1:0]  divider_accum_next;
  logic [dtr_pkg::ACCUM_W-1:0]  counter_accum_next;
  logic [7:0]                   counter_inc;
  logic [7:0]                   rd_value;
  logic                         cnt_en;

  function automatic logic [dtr_pkg::ACCUM_W-1:0] sat_add(
    input logic [dtr_pkg::ACCUM_W-1:0] acc,
    input logic [7:0]                  d
  );
    logic [dtr_pkg::ACCUM_W:0] sum;
    sum = {1'b0, acc} + (dtr_pkg::ACCUM_W + 1)'(d);
    sat_add = sum[dtr_pkg::ACCUM_W] ? dtr_pkg::ACCUM_MAX : sum[dtr_pkg::ACCUM_W-1:0];
  endfunction

  assign busy   = (state != S_IDLE);
  assign cnt_en = control_reg[dtr_pkg::CTRL_ENABLE_BIT];

  assign divider_accum_next = sat_add(divider_accum, delta_cycles);
  assign counter_accum_next = sat_add(counter_accum, delta_cycles);
  assign counter_inc        = counter_reg + 8'd1;

  always_comb begin
    if (state == S_DIV) begin
      sub_a = divider_accum;
      sub_b = dtr_pkg::eff_period(cfg.divider_period);
    end else begin
      sub_a = counter_accum;
      sub_b = dtr_pkg::eff_period(cfg.counter_period[control_reg[1:0]]);
    end
  end

  dtr_sub u_sub (
    .a    (sub_a),
    .b    (sub_b),
    .diff (sub_diff),
    .ge   (sub_ge)
  );

  always_comb begin
    case (address)
      dtr_pkg::ADDR_DIVIDER: rd_value = divider_reg;
      dtr_pkg::ADDR_COUNTER: rd_value = counter_reg;
      dtr_pkg::ADDR_MODULO:  rd_value = modulo_reg;
      dtr_pkg::ADDR_CONTROL: rd_value = control_reg;
      default:               rd_value = dtr_pkg::UNMAPPED_READ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      divider_reg   <= '0;
      counter_reg   <= '0;
      modulo_reg    <= '0;
      control_reg   <= '0;
      divider_accum <= '0;
      counter_accum <= '0;
      irq_flag      <= 1'b0;
      done          <= 1'b0;
      read_data     <= '0;
      timer_irq     <= 1'b0;
    end else begin
      done      <= 1'b0;
      read_data <= '0;
      timer_irq <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            case (kind)
              dtr_pkg::KIND_TICK: begin
                divider_accum <= divider_accum_next;
                if (cnt_en) begin
                  counter_accum <= counter_accum_next;
                end
                irq_flag <= 1'b0;
                state    <= S_DIV;
              end
              dtr_pkg::KIND_WRITE: begin
                case (address)
                  dtr_pkg::ADDR_DIVIDER: divider_reg <= write_data;
                  dtr_pkg::ADDR_COUNTER: counter_reg <= write_data;
                  dtr_pkg::ADDR_MODULO:  modulo_reg  <= write_data;
                  dtr_pkg::ADDR_CONTROL: control_reg <= write_data;
                  default: ;
                endcase
                done <= 1'b1;
              end
              dtr_pkg::KIND_READ: begin
                read_data <= rd_value;
                done      <= 1'b1;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_DIV: begin
          if (sub_ge) begin
            divider_accum <= sub_diff;
            divider_reg   <= divider_reg + 8'd1;
          end
          if (cnt_en) begin
            state <= S_CNT;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_CNT: begin
          if (sub_ge) begin
            counter_accum <= sub_diff;
            if (counter_inc == 8'd0) begin
              counter_reg <= modulo_reg;
              irq_flag    <= 1'b1;
            end else begin
              counter_reg <= counter_inc;
            end
          end else begin
            done      <= 1'b1;
            timer_irq <= irq_flag;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/divider_timer_with_reload_unit.sv
// Top level of the divider/counter timer with modulo reload.
// Depends on dtr_pkg, dtr_apb_regs, dtr_seq and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage:
//   Command channel: drive kind, address, write_data and delta_cycles with start;
//   the transfer happens at an edge where start is high and busy is low.
//   Result channel: done is high for one cycle with read_data and timer_irq;
//   the receiver takes it in that cycle and cannot stall it.
//   Config: APB registers at 0x00 divider period, 0x04..0x10 counter periods for
//   select 0..3 (16 bits each); pready is tied high. Write only while idle.
// Command flow:
//   Read, write and unknown kind: result in the cycle after the transfer, busy stays
//   low, so a new command may follow every cycle.
//   Tick with counter disabled: the transfer enters the divider step, which returns
//   to idle with the result. Tick with counter enabled: the divider step, then the
//   counter step once per whole counter period in the counter accumulator; one
//   compare/subtract unit handles one period per cycle, shared with the divider step.
// Reset: all timer registers and accumulators clear, periods take 256, 1024, 16,
//   64 and 256; no result is pending.
module divider_timer_with_reload_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   kind,
  input  logic [15:0]                  address,
  input  logic [7:0]                   write_data,
  input  logic [7:0]                   delta_cycles,
  output logic                         done,
  output logic [7:0]                   read_data,
  output logic                         timer_irq,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dtr_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  dtr_pkg::cfg_t cfg;

  dtr_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dtr_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .address      (address),
    .write_data   (write_data),
    .delta_cycles (delta_cycles),
    .cfg          (cfg),
    .done         (done),
    .read_data    (read_data),
    .timer_irq    (timer_irq)
  );

  `ASSERT_IMPL(a_done_idle, done, !busy, "result strobe while busy")
  `ASSERT_NEXT(a_cmd_progress, start && !busy, busy || done, "command dropped")
  `ASSERT_IMPL(a_irq_strobe, timer_irq, done, "irq outside result strobe")
  `ASSERT_IMPL(a_rdata_strobe, read_data != 8'h00, done, "read data outside result strobe")

endmodule
